// File: hw/rtl/ara_pkg.sv
// Shared types and codes for the address region allocator.
package ara_pkg;

    localparam int PAGE_W          = 52;
    localparam int ATTR_W          = 8;
    localparam int STAT_W          = 3;
    localparam int OP_W            = 2;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 64;
    localparam int MAX_REGIONS_DEF = 64;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [PAGE_W:0]   page_sum_t;
    typedef logic [PAGE_W+1:0] page_wide_t;

    typedef struct packed {
        page_t             base;
        page_t             length;
        logic              kind;
        logic [ATTR_W-1:0] attr;
    } entry_t;

    localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
    localparam logic [OP_W-1:0] OP_KMAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FIXED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd4;

    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

endpackage

// File: hw/rtl/ara_table.sv
// Region table memory with one write port and one registered read port.
module ara_table #(
    parameter int DEPTH = ara_pkg::MAX_REGIONS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ara_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output ara_pkg::entry_t rdata
);

    ara_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/ara_engine.sv
// Sequencer and shared compare datapath that walks the sorted region table.
module ara_engine #(
    parameter int MAX_REGIONS = ara_pkg::MAX_REGIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ara_pkg::page_t             low_limit,
    input  ara_pkg::page_t             high_limit,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ara_pkg::OP_W-1:0]   op,
    input  ara_pkg::page_t             req_page,
    input  ara_pkg::page_t             req_pages,
    input  logic                       fixed_placement,
    input  logic [ara_pkg::ATTR_W-1:0] seg_attr,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ara_pkg::STAT_W-1:0] status,
    output ara_pkg::page_t             region_page,
    output ara_pkg::page_t             region_pages,
    output logic                       region_kind,
    output logic [ara_pkg::ATTR_W-1:0] region_attr
);

    localparam int AW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_REGIONS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVL,
        S_FIT,
        S_POS,
        S_LOOK,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic [CW-1:0]                pidx_reg, pidx_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic                         posf_reg, posf_next;
    logic                         ovl_reg, ovl_next;
    ara_pkg::page_t               base_reg, base_next;
    ara_pkg::page_t               len_reg, len_next;
    ara_pkg::page_sum_t           end_reg, end_next;
    ara_pkg::page_sum_t           start_reg, start_next;
    logic                         fixed_reg, fixed_next;
    logic                         kind_reg, kind_next;
    logic [ara_pkg::ATTR_W-1:0]   attr_reg, attr_next;
    logic [ara_pkg::STAT_W-1:0]   res_status_reg, res_status_next;
    ara_pkg::page_t               res_page_reg, res_page_next;
    ara_pkg::page_t               res_pages_reg, res_pages_next;
    logic                         res_kind_reg, res_kind_next;
    logic [ara_pkg::ATTR_W-1:0]   res_attr_reg, res_attr_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ara_pkg::STAT_W-1:0]   status_reg, status_next;
    ara_pkg::page_t               region_page_reg, region_page_next;
    ara_pkg::page_t               region_pages_reg, region_pages_next;
    logic                         region_kind_reg, region_kind_next;
    logic [ara_pkg::ATTR_W-1:0]   region_attr_reg, region_attr_next;

    logic                         we;
    logic [AW-1:0]                waddr;
    ara_pkg::entry_t              wdata;
    logic [AW-1:0]                raddr;
    ara_pkg::entry_t              e;

    ara_pkg::page_sum_t           e_end;
    ara_pkg::page_wide_t          fit_sum;
    logic [CW-1:0]                sh_m1;
    logic [CW-1:0]                wpidx;
    logic                         issue_scan;
    logic                         issue_shift;
    logic                         ovl_hit;
    logic                         pos_hit;
    logic                         look_hit;
    logic                         fit_break;
    logic                         fit_ok;
    logic                         fit_done;
    logic                         in_bounds;
    ara_pkg::entry_t              new_entry;

    ara_table #(.DEPTH(MAX_REGIONS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (e)
    );

    assign e_end       = {1'b0, e.base} + {1'b0, e.length};
    assign fit_sum     = {1'b0, start_reg} + {2'b00, len_reg};
    assign sh_m1       = idx_reg - CW'(1);
    assign wpidx       = pidx_reg + CW'(1);
    assign issue_scan  = idx_reg < count_reg;
    assign issue_shift = idx_reg > pos_reg;
    assign ovl_hit     = (e.length != '0) && ({1'b0, base_reg} < e_end)
                         && ({1'b0, e.base} < end_reg);
    assign pos_hit     = e.base >= base_reg;
    assign look_hit    = (e.base <= base_reg) && ({1'b0, base_reg} < e_end);
    assign fit_break   = fit_sum <= {2'b00, e.base};
    assign fit_ok      = fit_sum <= ({2'b00, high_limit} + ara_pkg::page_wide_t'(1));
    assign in_bounds   = (base_reg >= low_limit)
                         && (end_reg <= ({1'b0, high_limit} + ara_pkg::page_sum_t'(1)));
    assign new_entry   = '{base: base_reg, length: len_reg, kind: kind_reg, attr: attr_reg};
    assign raddr       = (state_reg == S_SHIFT) ? sh_m1[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pend_next         = 1'b0;
        pidx_next         = pidx_reg;
        pos_next          = pos_reg;
        posf_next         = posf_reg;
        ovl_next          = ovl_reg;
        base_next         = base_reg;
        len_next          = len_reg;
        end_next          = end_reg;
        start_next        = start_reg;
        fixed_next        = fixed_reg;
        kind_next         = kind_reg;
        attr_next         = attr_reg;
        res_status_next   = res_status_reg;
        res_page_next     = res_page_reg;
        res_pages_next    = res_pages_reg;
        res_kind_next     = res_kind_reg;
        res_attr_next     = res_attr_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        region_page_next  = region_page_reg;
        region_pages_next = region_pages_reg;
        region_kind_next  = region_kind_reg;
        region_attr_next  = region_attr_reg;
        we                = 1'b0;
        waddr             = pos_reg[AW-1:0];
        wdata             = new_entry;
        fit_done          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    base_next       = req_page;
                    len_next        = req_pages;
                    end_next        = {1'b0, req_page} + {1'b0, req_pages};
                    fixed_next      = fixed_placement;
                    attr_next       = seg_attr;
                    kind_next       = (op == ara_pkg::OP_KMAP);
                    idx_next        = '0;
                    pos_next        = count_reg;
                    posf_next       = 1'b0;
                    ovl_next        = 1'b0;
                    start_next      = {1'b0, low_limit};
                    res_status_next = ara_pkg::ST_MISS;
                    res_page_next   = '0;
                    res_pages_next  = '0;
                    res_kind_next   = 1'b0;
                    res_attr_next   = '0;
                    case (op)
                        ara_pkg::OP_MAP:
                        begin
                            if (req_pages == '0)
                            begin
                                res_status_next = ara_pkg::ST_NOSPACE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_OVL;
                            end
                        end
                        ara_pkg::OP_KMAP:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = ara_pkg::ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_POS;
                            end
                        end
                        ara_pkg::OP_LOOKUP:
                        begin
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_OVL:
            begin
                if (pend_reg)
                begin
                    if (ovl_hit)
                    begin
                        ovl_next = 1'b1;
                    end
                    if (!posf_reg && pos_hit)
                    begin
                        pos_next  = pidx_reg;
                        posf_next = 1'b1;
                    end
                end
                if (issue_scan)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                else if (!pend_reg)
                begin
                    if (in_bounds && !ovl_reg)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            res_status_next = ara_pkg::ST_FULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_SHIFT;
                        end
                    end
                    else if (fixed_reg)
                    begin
                        res_status_next = ara_pkg::ST_FIXED;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_FIT;
                    end
                end
            end

            S_FIT:
            begin
                if (pend_reg && fit_break)
                begin
                    fit_done = 1'b1;
                end
                else
                begin
                    if (pend_reg && (e_end > start_reg))
                    begin
                        start_next = e_end;
                    end
                    if (issue_scan)
                    begin
                        idx_next  = idx_reg + CW'(1);
                        pend_next = 1'b1;
                        pidx_next = idx_reg;
                    end
                    else if (!pend_reg)
                    begin
                        fit_done = 1'b1;
                    end
                end
                if (fit_done)
                begin
                    if (!fit_ok)
                    begin
                        res_status_next = ara_pkg::ST_NOSPACE;
                        state_next      = S_RESP;
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        res_status_next = ara_pkg::ST_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        base_next  = start_reg[ara_pkg::PAGE_W-1:0];
                        idx_next   = '0;
                        pos_next   = count_reg;
                        state_next = S_POS;
                    end
                end
            end

            S_POS:
            begin
                if (pend_reg && pos_hit)
                begin
                    pos_next   = pidx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT;
                end
                else if (issue_scan)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                else if (!pend_reg)
                begin
                    pos_next   = count_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT;
                end
            end

            S_LOOK:
            begin
                if (pend_reg && look_hit)
                begin
                    res_status_next = ara_pkg::ST_OK;
                    res_page_next   = e.base;
                    res_pages_next  = e.length;
                    res_kind_next   = e.kind;
                    res_attr_next   = e.attr;
                    state_next      = S_RESP;
                end
                else if (issue_scan)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                else if (!pend_reg)
                begin
                    state_next = S_RESP;
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = wpidx[AW-1:0];
                    wdata = e;
                end
                if (issue_shift)
                begin
                    idx_next  = sh_m1;
                    pend_next = 1'b1;
                    pidx_next = sh_m1;
                end
                else if (!pend_reg)
                begin
                    we              = 1'b1;
                    waddr           = pos_reg[AW-1:0];
                    wdata           = new_entry;
                    count_next      = count_reg + CW'(1);
                    res_status_next = ara_pkg::ST_OK;
                    res_page_next   = base_reg;
                    res_pages_next  = len_reg;
                    res_kind_next   = kind_reg;
                    res_attr_next   = attr_reg;
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    region_page_next  = res_page_reg;
                    region_pages_next = res_pages_reg;
                    region_kind_next  = res_kind_reg;
                    region_attr_next  = res_attr_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            pend_reg         <= 1'b0;
            pidx_reg         <= '0;
            pos_reg          <= '0;
            posf_reg         <= 1'b0;
            ovl_reg          <= 1'b0;
            base_reg         <= '0;
            len_reg          <= '0;
            end_reg          <= '0;
            start_reg        <= '0;
            fixed_reg        <= 1'b0;
            kind_reg         <= 1'b0;
            attr_reg         <= '0;
            res_status_reg   <= ara_pkg::ST_MISS;
            res_page_reg     <= '0;
            res_pages_reg    <= '0;
            res_kind_reg     <= 1'b0;
            res_attr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ara_pkg::ST_MISS;
            region_page_reg  <= '0;
            region_pages_reg <= '0;
            region_kind_reg  <= 1'b0;
            region_attr_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            pend_reg         <= pend_next;
            pidx_reg         <= pidx_next;
            pos_reg          <= pos_next;
            posf_reg         <= posf_next;
            ovl_reg          <= ovl_next;
            base_reg         <= base_next;
            len_reg          <= len_next;
            end_reg          <= end_next;
            start_reg        <= start_next;
            fixed_reg        <= fixed_next;
            kind_reg         <= kind_next;
            attr_reg         <= attr_next;
            res_status_reg   <= res_status_next;
            res_page_reg     <= res_page_next;
            res_pages_reg    <= res_pages_next;
            res_kind_reg     <= res_kind_next;
            res_attr_reg     <= res_attr_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            region_page_reg  <= region_page_next;
            region_pages_reg <= region_pages_next;
            region_kind_reg  <= region_kind_next;
            region_attr_reg  <= region_attr_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign region_page  = region_page_reg;
    assign region_pages = region_pages_reg;
    assign region_kind  = region_kind_reg;
    assign region_attr  = region_attr_reg;

endmodule

// File: hw/rtl/address_region_allocator.sv
// Top level of the address region allocator with its register port.
// Each item walks the N stored regions through one table read port, in one or more passes.
// A lookup takes one scan; a kernel map takes a position pass and then a shift.
// A checked map: overlap pass (also finds the slot), fit and position passes if moved, shift.
// One item is in flight at a time; a finished result waits in the output register.
// Reset empties the table at once (no clearing pass) and sets the limits to 0 and all ones.
module address_region_allocator #(
    parameter int MAX_REGIONS = ara_pkg::MAX_REGIONS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ara_pkg::ADDR_W-1:0]  paddr,
    input  logic [ara_pkg::DATA_W-1:0]  pwdata,
    output logic [ara_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ara_pkg::OP_W-1:0]    op,
    input  ara_pkg::page_t              req_page,
    input  ara_pkg::page_t              req_pages,
    input  logic                        fixed_placement,
    input  logic [ara_pkg::ATTR_W-1:0]  seg_attr,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ara_pkg::STAT_W-1:0]  status,
    output ara_pkg::page_t              region_page,
    output ara_pkg::page_t              region_pages,
    output logic                        region_kind,
    output logic [ara_pkg::ATTR_W-1:0]  region_attr
);

    ara_pkg::page_t low_limit_reg;
    ara_pkg::page_t high_limit_reg;
    logic           wr_en;
    logic           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= '0;
            high_limit_reg <= '1;
        end
        else if (wr_en)
        begin
            if (reg_sel == ara_pkg::REG_LOW)
            begin
                low_limit_reg <= pwdata[ara_pkg::PAGE_W-1:0];
            end
            else
            begin
                high_limit_reg <= pwdata[ara_pkg::PAGE_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            ara_pkg::REG_LOW:  prdata = ara_pkg::DATA_W'(low_limit_reg);
            ara_pkg::REG_HIGH: prdata = ara_pkg::DATA_W'(high_limit_reg);
            default:           prdata = '0;
        endcase
    end

    ara_engine #(.MAX_REGIONS(MAX_REGIONS)) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .low_limit       (low_limit_reg),
        .high_limit      (high_limit_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .req_page        (req_page),
        .req_pages       (req_pages),
        .fixed_placement (fixed_placement),
        .seg_attr        (seg_attr),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .region_page     (region_page),
        .region_pages    (region_pages),
        .region_kind     (region_kind),
        .region_attr     (region_attr)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a second item right after accepting one");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ara_pkg::ST_OK)) |->
        ((region_page == '0) && (region_pages == '0) && !region_kind && (region_attr == '0)))
        else $error("failed result carries nonzero region fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ara_pkg::ST_MISS))
        else $error("result status outside the defined codes");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

endmodule
